// File: design/websocket_frame_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// websocket frame deframer assertion macros
// shared property forms used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define WSDF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define WSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // width of the payload length counter, 16 to 64
  localparam int unsigned LENGTH_WIDTH = 64;

  // stream bus widths
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 16;
  localparam int unsigned TUSER_OUT_W = 2;

  // frame header constants
  localparam logic [3:0] OPCODE_CLOSE = 4'h8;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;

  // byte counts of the header fields, eight wraps to zero in three bits
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] MASK_BYTES  = 3'd4;

  typedef logic [LENGTH_WIDTH-1:0] len_t;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // one result item
  typedef struct packed {
    logic       close_seen;
    logic       empty_frame;
    logic       last_in_frame;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic [7:0] payload_byte;
  } result_t;

endpackage

// File: design/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// websocket frame deframer: header parse and payload unmask per byte
// ----------------------------------------------------------------------------
// The slave stream carries raw connection bytes, one per transaction in
// s_axis_tdata. The master stream gives one transaction per payload byte,
// unmasked, with the frame's fin and opcode; tlast marks the frame's final
// transaction. A frame without payload gives one transaction with the empty
// flag in tuser and zero data. Header, extended length and mask key bytes
// give no transaction. Once a close frame has finished, every later byte is
// taken and dropped until reset.
// Throughput is one byte per cycle while s_axis_tready is high: the parser
// state updates in the same cycle a byte is accepted. The byte's result is
// registered and raises m_axis_tvalid next cycle unless the master stalls.
// When the receiver stalls, one result sits in the output register and one
// more in a skid register; s_axis_tready then drops until the skid empties.
// Reset clears the parser to the first header byte, drops any held result
// and reopens the stream after a close.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: stream_byte[7:0]
  input  logic [wsdf_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: payload_byte[7:0], frame_fin[8], frame_opcode[12:9], zero[15:13]
  output logic [wsdf_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // tuser: empty_frame[0], close_seen[1]
  output logic [wsdf_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);
  import wsdf_pkg::*;

  logic    byte_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign byte_accept = s_axis_tvalid && s_axis_tready;

  // header parser and unmasker
  wsdf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_accept),
    .byte_i       (s_axis_tdata[7:0]),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // output register and skid
  wsdf_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  // bus packing
  assign m_axis_tdata = {3'b000, out_res.frame_opcode, out_res.frame_fin,
                         out_res.payload_byte};
  assign m_axis_tuser = {out_res.close_seen, out_res.empty_frame};
  assign m_axis_tlast = out_res.last_in_frame;

endmodule

// File: design/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser
// frame header parser and payload unmasker, one stream byte per cycle
// ----------------------------------------------------------------------------
module wsdf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,   // byte accepted this cycle
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output wsdf_pkg::result_t res_o
);
  import wsdf_pkg::*;

  phase_e     phase_q, phase_d;
  logic       fin_q, fin_d;
  logic [3:0] opcode_q, opcode_d;
  logic       masked_q, masked_d;
  len_t       len_q, len_d;
  logic [2:0] cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0] idx_q, idx_d;
  logic       closed_q, closed_d;

  len_t       len_dec;
  logic [7:0] key_byte;
  logic       hdr_end;
  logic       hdr_len_zero;
  logic [6:0] len7;
  logic       is_close;

  assign len_dec  = len_q - len_t'(1);
  assign len7     = byte_i[6:0];
  assign is_close = (opcode_q == OPCODE_CLOSE);
  assign key_byte = masked_q ? key_q[8*(3-idx_q) +: 8] : 8'h00;

  // next state and result
  always_comb begin
    phase_d      = phase_q;
    fin_d        = fin_q;
    opcode_d     = opcode_q;
    masked_d     = masked_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    idx_d        = idx_q;
    closed_d     = closed_q;
    hdr_end      = 1'b0;
    hdr_len_zero = 1'b0;
    res_valid_o  = 1'b0;
    res_o.payload_byte  = 8'h00;
    res_o.frame_fin     = fin_q;
    res_o.frame_opcode  = opcode_q;
    res_o.last_in_frame = 1'b0;
    res_o.empty_frame   = 1'b0;
    res_o.close_seen    = is_close;

    if (byte_valid_i && !closed_q) begin
      case (phase_q)
        PH_HDR1: begin
          masked_d = byte_i[7];
          if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
            len_d   = '0;
            cnt_d   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_d = PH_EXTLEN;
          end else begin
            len_d = len_t'(len7);
            if (byte_i[7]) begin
              cnt_d   = MASK_BYTES;
              phase_d = PH_MASK;
            end else begin
              hdr_end      = 1'b1;
              hdr_len_zero = (len7 == 7'd0);
            end
          end
        end
        PH_EXTLEN: begin
          // saturate once the length no longer fits
          if (|len_q[LENGTH_WIDTH-1 -: 8]) begin
            len_d = '1;
          end else begin
            len_d = {len_q[LENGTH_WIDTH-9:0], byte_i};
          end
          cnt_d = cnt_q - 3'd1;
          if (cnt_d == 3'd0) begin
            if (masked_q) begin
              cnt_d   = MASK_BYTES;
              phase_d = PH_MASK;
            end else begin
              hdr_end      = 1'b1;
              hdr_len_zero = (len_d == '0);
            end
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], byte_i};
          cnt_d = cnt_q - 3'd1;
          if (cnt_d == 3'd0) begin
            hdr_end      = 1'b1;
            hdr_len_zero = (len_q == '0);
          end
        end
        PH_PAYLOAD: begin
          idx_d               = idx_q + 2'd1;
          len_d               = len_dec;
          res_valid_o         = 1'b1;
          res_o.payload_byte  = byte_i ^ key_byte;
          res_o.last_in_frame = (len_dec == '0);
          if (len_dec == '0) begin
            closed_d = is_close;
            phase_d  = PH_HDR0;
          end
        end
        default: begin
          // first header byte, also taken for any stray phase code
          fin_d    = byte_i[7];
          opcode_d = byte_i[3:0];
          phase_d  = PH_HDR1;
        end
      endcase

      // header complete: empty frame result or start of payload
      if (hdr_end) begin
        if (hdr_len_zero) begin
          res_valid_o         = 1'b1;
          res_o.last_in_frame = 1'b1;
          res_o.empty_frame   = 1'b1;
          closed_d            = is_close;
          phase_d             = PH_HDR0;
        end else begin
          idx_d   = 2'd0;
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      fin_q    <= 1'b0;
      opcode_q <= 4'h0;
      masked_q <= 1'b0;
      len_q    <= '0;
      cnt_q    <= 3'd0;
      key_q    <= 32'h0;
      idx_q    <= 2'd0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      closed_q <= closed_d;
    end
  end

endmodule

// File: design/wsdf_out_skid.sv
// ----------------------------------------------------------------------------
// wsdf_out_skid
// result register with a skid stage, registered ready toward the parser
// ----------------------------------------------------------------------------
module wsdf_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  wsdf_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output wsdf_pkg::result_t out_data_o,
  input  logic              out_ready_i
);
  import wsdf_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    main_free;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign main_free   = !main_valid_q || out_ready_i;

  // main takes the skid entry first, then a fresh result
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = in_valid_i;
        main_d       = in_data_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// File: design/wsdf_checker.sv
// ----------------------------------------------------------------------------
// wsdf_checker
// port-level checks of the websocket frame deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_unit_defines.svh"

module wsdf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [wsdf_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic [wsdf_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);
  import wsdf_pkg::*;

  logic out_xfer;
  logic in_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  `WSDF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // empty frame result is the last one and carries zero data
  `WSDF_ASSERT_IMPL(a_empty, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[7:0] == 8'h00), "bad empty frame result")

  // nothing follows the final transaction of a close frame
  `WSDF_ASSERT_NEXT(a_close, out_xfer && m_axis_tlast && m_axis_tuser[1], !m_axis_tvalid, "result after close frame")

  // a result never appears without a byte accepted before it
  `WSDF_ASSERT_IMPL(a_cause, $rose(m_axis_tvalid), $past(in_xfer), "result with no input byte")

endmodule

bind websocket_frame_deframer_unit wsdf_checker u_wsdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
